// ===== rtl/ddcpll_pkg.sv =====
// ============================================================================
// ddcpll_pkg: shared types and constants of the carrier recovery loop
// Widths, slicer constants, the quarter-wave sine table and the command word
// that the controller hands to the datapath.
// ============================================================================
package ddcpll_pkg;

  // Basic formats.
  localparam int SW   = 16;  // sample width
  localparam int PW   = 24;  // oscillator phase and frequency width
  localparam int GS   = 20;  // gain shift
  localparam int AB   = 10;  // sine table address bits
  localparam int FRAC = 14;  // sample fraction bits
  localparam int GW   = 16;  // gain register width

  // Stream word widths, rounded up to whole bytes.
  localparam int IN_DW  = ((2 * SW + 7) / 8) * 8;
  localparam int OUT_DW = ((2 * SW + 2 * PW + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IW = 3;
  localparam int CFG_DW = (PW > GW) ? PW : GW;

  typedef enum logic [CFG_IW-1:0] {
    CFG_CONSTELLATION = 3'd0,
    CFG_PROP_GAIN     = 3'd1,
    CFG_INTEG_GAIN    = 3'd2,
    CFG_PHASE_INIT    = 3'd3,
    CFG_FREQ_INIT     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CONST_QPSK   = 2'd0,
    CONST_QAM16  = 2'd1,
    CONST_QAM64  = 2'd2,
    CONST_QAM256 = 2'd3
  } const_e;

  // Sine table: quarter wave plus the end point.
  localparam int QUARTER   = 2 ** (AB - 2);
  localparam int HALF      = 2 ** (AB - 1);
  localparam int ROM_DEPTH = QUARTER + 1;
  localparam int ROMW      = FRAC + 1;       // holds 0 .. 2^FRAC
  localparam int SINW      = FRAC + 2;       // signed sine or cosine

  // Datapath widths.
  localparam int PRODW = SW + SINW;          // rotation product
  localparam int RSUMW = PRODW + 1;          // rotation sum
  localparam int RW    = 17;                 // signed slicer scale, Q12
  localparam int XPW   = SW + RW;            // scaled sample product
  localparam int XW    = XPW - 12;           // scaled sample
  localparam int KSW   = XW + 2;             // slicer index sum
  localparam int LVW   = 6;                  // signed level, up to +-15 and 2k
  localparam int DW    = FRAC + 2;           // decision point
  localparam int EPW   = SW + DW;            // error product
  localparam int ESUMW = EPW + 1;            // error difference
  localparam int EW    = ESUMW - FRAC;       // phase error
  localparam int GPW   = GW + 1 + EW;        // gain product
  localparam int FACCW = ((PW > GPW) ? PW : GPW) + 1;

  localparam int    RND      = 2 ** (FRAC - 1);
  localparam int    SMAX     = 2 ** (SW - 1) - 1;
  localparam int    SMIN     = -(2 ** (SW - 1));
  localparam longint FMAX    = (longint'(1) <<< (PW - 1)) - 1;
  localparam longint FMIN    = -(longint'(1) <<< (PW - 1));
  localparam int    QPSK_LEVEL = 11585;

  // Polynomial constants for the table, Q28.
  localparam longint PI_Q28  = 843314857;
  localparam longint POLY_C7 = -50513;
  localparam longint POLY_C5 = 2234323;
  localparam longint POLY_C3 = -44738832;

  typedef logic [ROMW-1:0] sin_rom_t [ROM_DEPTH];

  // Odd polynomial over the folded angle, evaluated once at elaboration.
  function automatic sin_rom_t build_sin_rom();
    sin_rom_t rom;
    longint   d;
    longint   s;
    longint   u;
    longint   t;
    longint   r;
    for (int m = 0; m < ROM_DEPTH; m++) begin
      d = (longint'(m) * PI_Q28 + longint'(QUARTER)) >>> (AB - 1);
      s = (d * d) >>> 28;
      u = POLY_C7;
      u = ((u * s) >>> 28) + POLY_C5;
      u = ((u * s) >>> 28) + POLY_C3;
      t = (s * d) >>> 28;
      r = d + ((t * u) >>> 28);
      r = (r + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      if (r > (longint'(1) <<< FRAC)) r = longint'(1) <<< FRAC;
      if (r < 0) r = 0;
      rom[m] = ROMW'(r);
    end
    return rom;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin_rom();

  // Square QAM constants: scale to the integer grid (Q12), point spacing
  // (Q14) and levels per axis.
  function automatic int qam_r(input const_e sel);
    int v;
    case (sel)
      CONST_QAM16:  v = 12953;
      CONST_QAM64:  v = 26545;
      CONST_QAM256: v = 53405;
      default:      v = 0;
    endcase
    return v;
  endfunction

  function automatic int qam_s(input const_e sel);
    int v;
    case (sel)
      CONST_QAM16:  v = 5181;
      CONST_QAM64:  v = 2528;
      CONST_QAM256: v = 1257;
      default:      v = 0;
    endcase
    return v;
  endfunction

  function automatic int qam_l(input const_e sel);
    int v;
    case (sel)
      CONST_QAM16:  v = 4;
      CONST_QAM64:  v = 8;
      CONST_QAM256: v = 16;
      default:      v = 2;
    endcase
    return v;
  endfunction

  // Controller state; each state after idle drives one datapath step.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT_I,
    ST_ROT_Q,
    ST_ROUND_Q,
    ST_SCALE,
    ST_DECIDE,
    ST_ERR_MUL,
    ST_ERR_SUB,
    ST_GAIN,
    ST_UPDATE
  } ctrl_state_e;

  typedef struct packed {
    logic load;      // take the input word and look up sine and cosine
    logic rot_i;     // in-phase rotation products
    logic rot_q;     // round in-phase, quadrature rotation products
    logic round_q;   // round quadrature
    logic scale;     // scale both rails to the slicer grid
    logic decide;    // nearest constellation point
    logic err_mul;   // error cross products
    logic err_sub;   // error difference
    logic gain;      // loop gain products
    logic update;    // new frequency and phase, load output word
  } dp_cmd_t;

endpackage

// ===== rtl/ddcpll_ctrl.sv =====
// ============================================================================
// ddcpll_ctrl: sequencer of the carrier recovery loop
// Steps the datapath through one symbol and owns the stream handshakes.
// ============================================================================
module ddcpll_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ddcpll_pkg::dp_cmd_t cmd_o
);
  import ddcpll_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ROT_I;
        end
      end
      ST_ROT_I: begin
        cmd_o.rot_i = 1'b1;
        state_d     = ST_ROT_Q;
      end
      ST_ROT_Q: begin
        cmd_o.rot_q = 1'b1;
        state_d     = ST_ROUND_Q;
      end
      ST_ROUND_Q: begin
        cmd_o.round_q = 1'b1;
        state_d       = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_ERR_MUL;
      end
      ST_ERR_MUL: begin
        cmd_o.err_mul = 1'b1;
        state_d       = ST_ERR_SUB;
      end
      ST_ERR_SUB: begin
        cmd_o.err_sub = 1'b1;
        state_d       = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = ST_UPDATE;
      end
      ST_UPDATE: begin
        // The loop state moves only when the result can be stored.
        if (out_free) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.update) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

// ===== rtl/ddcpll_datapath.sv =====
// ============================================================================
// ddcpll_datapath: arithmetic of the carrier recovery loop
// Derotation, slicer, phase error, loop filter, oscillator and the
// configuration registers.
// ============================================================================
module ddcpll_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ddcpll_pkg::dp_cmd_t                 cmd_i,
  input  logic [ddcpll_pkg::IN_DW-1:0]        in_data_i,
  output logic [ddcpll_pkg::OUT_DW-1:0]       out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ddcpll_pkg::CFG_IW-1:0]       cfg_idx_i,
  input  logic [ddcpll_pkg::CFG_DW-1:0]       cfg_data_i
);
  import ddcpll_pkg::*;

  // Configuration and loop state.
  const_e                 constellation_q;
  logic [GW-1:0]          prop_gain_q;
  logic [GW-1:0]          integ_gain_q;
  logic [PW-1:0]          phase_q;
  logic signed [PW-1:0]   freq_q;

  // Work registers.
  logic signed [SW-1:0]    xi_q, xq_q;
  logic signed [SINW-1:0]  sin_q, cos_q;
  logic signed [PRODW-1:0] pa_q, pb_q;
  logic signed [SW-1:0]    yi_q, yq_q;
  logic signed [XW-1:0]    xsi_q, xsq_q;
  logic signed [DW-1:0]    di_q, dq_q;
  logic signed [EPW-1:0]   ea_q, eb_q;
  logic signed [EW-1:0]    e_q;
  logic signed [GPW-1:0]   gi_q, gp_q;

  // Output word.
  logic signed [SW-1:0]    out_i_q, out_q_q;
  logic [PW-1:0]           out_phase_q;
  logic signed [PW-1:0]    out_freq_q;

  logic [PW+AB-1:0]        phase_ext;
  logic [AB-1:0]           addr_sin, addr_cos;
  logic signed [RW-1:0]    scale_r;
  logic signed [FACCW-1:0] freq_sum;
  logic signed [PW-1:0]    freq_new;
  logic [PW-1:0]           phase_step;
  logic [PW-1:0]           phase_new;

  function automatic logic signed [SINW-1:0] sin_lookup(input logic [AB-1:0] a);
    logic [AB-2:0]   m;
    logic [ROMW-1:0] v;
    m = a[AB-2:0];
    if (m > (AB-1)'(QUARTER)) m = (AB-1)'(HALF) - m;
    v = SIN_ROM[m];
    return a[AB-1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  function automatic logic signed [SW-1:0] round_sat(input logic signed [RSUMW-1:0] v);
    logic signed [RSUMW-1:0] r;
    r = (v + RSUMW'(RND)) >>> FRAC;
    if (r > RSUMW'(SMAX)) return SW'(SMAX);
    if (r < RSUMW'(SMIN)) return SW'(SMIN);
    return SW'(r);
  endfunction

  function automatic logic signed [DW-1:0] slice(input logic signed [SW-1:0] y,
                                                 input logic signed [XW-1:0] x,
                                                 input const_e sel);
    logic signed [KSW-1:0] k;
    logic signed [LVW-1:0] lvl;
    int                    lsize;
    lsize = qam_l(sel);
    if (sel == CONST_QPSK) begin
      return (y < 0) ? -DW'(QPSK_LEVEL) : DW'(QPSK_LEVEL);
    end
    k = (KSW'(x) + KSW'(lsize * (2 ** FRAC))) >>> (FRAC + 1);
    if (k < 0) begin
      k = '0;
    end else if (k > KSW'(lsize - 1)) begin
      k = KSW'(lsize - 1);
    end
    lvl = LVW'(k <<< 1) - LVW'(lsize - 1);
    return DW'(lvl) * DW'(qam_s(sel));
  endfunction

  // Top table-address bits of the phase; works for either width order.
  assign phase_ext = {phase_q, {AB{1'b0}}};
  assign addr_sin  = phase_ext[PW+AB-1 -: AB];
  assign addr_cos  = addr_sin + AB'(QUARTER);
  assign scale_r   = RW'(qam_r(constellation_q));

  // Loop filter: saturating frequency, wrapping phase.
  always_comb begin
    freq_sum = FACCW'(freq_q) + FACCW'(gi_q >>> GS);
    if (freq_sum > FACCW'(FMAX)) begin
      freq_new = PW'(FMAX);
    end else if (freq_sum < FACCW'(FMIN)) begin
      freq_new = PW'(FMIN);
    end else begin
      freq_new = PW'(freq_sum);
    end
    phase_step = PW'(gp_q >>> GS);
    phase_new  = phase_q + $unsigned(freq_new) + phase_step;
  end

  // Configuration registers and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      constellation_q <= CONST_QPSK;
      prop_gain_q     <= '0;
      integ_gain_q    <= '0;
      phase_q         <= '0;
      freq_q          <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CONSTELLATION: constellation_q <= const_e'(cfg_data_i[1:0]);
        CFG_PROP_GAIN:     prop_gain_q     <= cfg_data_i[GW-1:0];
        CFG_INTEG_GAIN:    integ_gain_q    <= cfg_data_i[GW-1:0];
        CFG_PHASE_INIT:    phase_q         <= cfg_data_i[PW-1:0];
        CFG_FREQ_INIT:     freq_q          <= $signed(cfg_data_i[PW-1:0]);
        default:           ;
      endcase
    end else if (cmd_i.update) begin
      freq_q  <= freq_new;
      phase_q <= phase_new;
    end
  end

  // Work registers, one step per command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xi_q  <= $signed(in_data_i[SW-1:0]);
      xq_q  <= $signed(in_data_i[2*SW-1:SW]);
      sin_q <= sin_lookup(addr_sin);
      cos_q <= sin_lookup(addr_cos);
    end
    if (cmd_i.rot_i) begin
      pa_q <= PRODW'(xi_q) * PRODW'(cos_q);
      pb_q <= PRODW'(xq_q) * PRODW'(sin_q);
    end
    if (cmd_i.rot_q) begin
      yi_q <= round_sat(RSUMW'(pa_q) + RSUMW'(pb_q));
      pa_q <= PRODW'(xq_q) * PRODW'(cos_q);
      pb_q <= PRODW'(xi_q) * PRODW'(sin_q);
    end
    if (cmd_i.round_q) begin
      yq_q <= round_sat(RSUMW'(pa_q) - RSUMW'(pb_q));
    end
    if (cmd_i.scale) begin
      xsi_q <= XW'((XPW'(yi_q) * XPW'(scale_r)) >>> 12);
      xsq_q <= XW'((XPW'(yq_q) * XPW'(scale_r)) >>> 12);
    end
    if (cmd_i.decide) begin
      di_q <= slice(yi_q, xsi_q, constellation_q);
      dq_q <= slice(yq_q, xsq_q, constellation_q);
    end
    if (cmd_i.err_mul) begin
      ea_q <= EPW'(yq_q) * EPW'(di_q);
      eb_q <= EPW'(yi_q) * EPW'(dq_q);
    end
    if (cmd_i.err_sub) begin
      e_q <= EW'((ESUMW'(ea_q) - ESUMW'(eb_q)) >>> FRAC);
    end
    if (cmd_i.gain) begin
      gi_q <= GPW'($signed({1'b0, integ_gain_q})) * GPW'(e_q);
      gp_q <= GPW'($signed({1'b0, prop_gain_q})) * GPW'(e_q);
    end
    if (cmd_i.update) begin
      out_i_q     <= yi_q;
      out_q_q     <= yq_q;
      out_phase_q <= phase_new;
      out_freq_q  <= freq_new;
    end
  end

  assign out_data_o = OUT_DW'({out_freq_q, out_phase_q, out_q_q, out_i_q});

endmodule

// ===== rtl/decision_directed_carrier_pll.sv =====
// ============================================================================
// decision_directed_carrier_pll: decision-directed carrier recovery loop
// Derotates QPSK or square QAM symbols with a table oscillator and tracks
// the carrier with a second-order loop.
// ============================================================================
// Timing: the result word is registered at the loop update of its symbol.
// One word is in work at a time; the next word is taken in the cycle
// after the loop update, since the oscillator phase of one symbol feeds the
// table lookup of the next.
// Reset: asynchronous and active low; phase, frequency, gains and the
// constellation clear to zero and no result is pending.
module decision_directed_carrier_pll (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream. tdata, lowest bit up: in_i, in_q.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ddcpll_pkg::IN_DW-1:0]      s_axis_tdata,
  // Result stream. tdata, lowest bit up: out_i, out_q, phase_now, freq_now.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ddcpll_pkg::OUT_DW-1:0]     m_axis_tdata,
  // Configuration writes: constellation, prop_gain, integ_gain,
  // phase_init, freq_init at indexes 0 to 4.
  input  logic                              cfg_we_i,
  input  logic [ddcpll_pkg::CFG_IW-1:0]     cfg_idx_i,
  input  logic [ddcpll_pkg::CFG_DW-1:0]     cfg_data_i
);
  import ddcpll_pkg::*;

  // The controller walks one symbol through the datapath: table lookup,
  // the rotation steps, slicer scaling and decision, phase error, loop
  // gains and finally the oscillator update. The result word sits in an
  // output register, so a new symbol is taken while it waits; the loop
  // update of the following symbol waits until that register is free.
  dp_cmd_t cmd;

  ddcpll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Writes to phase_init or freq_init load the oscillator state at once.
  ddcpll_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule

// ===== rtl/ddcpll_checker.sv =====
// ============================================================================
// ddcpll_checker: port-level checks of the carrier recovery loop
// Watches the stream ports for handshake and sequencing slips.
// ============================================================================
module ddcpll_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [ddcpll_pkg::OUT_DW-1:0]     m_axis_tdata
);

  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Only one symbol is in flight.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken while a symbol is in flight");

  // A new result appears only at the end of a symbol's work.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work in progress");

  // The input is still blocked late in the symbol's work.
  a_work_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ##7 !s_axis_tready)
    else $error("input taken before the symbol finished");

endmodule

bind decision_directed_carrier_pll ddcpll_checker u_ddcpll_checker (.*);
